// File: rtl/core/tlbl_pkg.sv
// shared types and codes of the translation buffer
package tlbl_pkg;

  typedef enum logic [1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_FILL   = 2'd1,
    KIND_INVAL  = 2'd2,
    KIND_FLUSH  = 2'd3
  } kind_e;

  localparam int unsigned PID_W     = 16;
  localparam int unsigned PAGE_W    = 12;
  localparam int unsigned FRAME_W   = 12;
  localparam int unsigned STAMP_W   = 32;
  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned CFG_W     = 5;
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  typedef struct packed {
    kind_e               kind;
    logic [PID_W-1:0]    process_id;
    logic [PAGE_W-1:0]   page_number;
    logic [FRAME_W-1:0]  frame_number;
  } in_word_t;

  typedef struct packed {
    logic                hit;
    logic [FRAME_W-1:0]  frame_out;
    logic [SLOT_W-1:0]   slot_used;
  } out_word_t;

  // one entry of the buffer as held in memory
  typedef struct packed {
    logic [PID_W-1:0]    pid;
    logic [PAGE_W-1:0]   page;
    logic [FRAME_W-1:0]  frame;
    logic [STAMP_W-1:0]  stamp;
  } entry_t;

endpackage

// File: rtl/core/tlb_lru_translation_core.sv
// translation buffer with lru replacement: control, scan sequencer and valid bits
//
//  channel  | signals                               | direction
//  ---------+---------------------------------------+----------
//  request  | in_valid_i, in_stall_o, in_word_i      | in
//  result   | out_valid_o, out_stall_i, out_word_o   | out
//  config   | cfg_we_i, cfg_wdata_i                  | in
//
// one word at a time; entries are read one per cycle through the single read
// port of the entry memory. with n active entries: a lookup scans up to n, a
// fill takes a free entry directly or scans all n for a victim, an invalidate
// scans all ENTRIES and a flush clears every valid bit. reset clears the valid
// bits at once, so no clearing pass is needed. a new word is taken while a
// result waits; the last step waits for the output register to be free.
module tlb_lru_translation_core
  import tlbl_pkg::*;
#(
  parameter int unsigned ENTRIES = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_word_t         in_word_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_word_t        out_word_o,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i
);

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  // control state
  logic [1:0]         state_q, state_d;
  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [STAMP_W-1:0] counter_q, counter_d;
  logic [CFG_W-1:0]   cfg_q;
  logic               out_valid_q, out_valid_d;
  logic               issue_q, issue_d;
  logic               chk_q, chk_d;
  logic               wr_q, wr_d;
  logic               hit_q, hit_d;

  // payload
  in_word_t           req_q, req_d;
  logic [IDX_W-1:0]   addr_q, addr_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [IDX_W-1:0]   last_q, last_d;
  logic [IDX_W-1:0]   vic_q, vic_d;
  logic [IDX_W-1:0]   slot_q, slot_d;
  logic [STAMP_W-1:0] best_q, best_d;
  entry_t             ent_q, ent_d;
  out_word_t          out_q, out_d;

  logic [CNT_W-1:0]   n_cnt;
  logic               free_found;
  logic [IDX_W-1:0]   free_idx;
  logic [STAMP_W-1:0] counter_inc;
  logic               out_free;
  logic               scan_hit;
  logic               scan_end;
  logic               older;

  logic               ram_we;
  logic               ram_re;
  entry_t             ram_wdata;
  entry_t             ram_rdata;

  tlbl_entry_ram #(
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (addr_q),
    .rdata_o (ram_rdata)
  );

  // active entry count, capped at the buffer size
  always_comb begin
    if (int'(cfg_q) > int'(ENTRIES)) begin
      n_cnt = CNT_W'(ENTRIES);
    end else begin
      n_cnt = CNT_W'(cfg_q);
    end
  end

  // lowest free active entry
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (i < int'(n_cnt) && !valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  assign counter_inc = (counter_q == '1) ? counter_q : counter_q + STAMP_W'(1);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign scan_hit    = chk_q && valid_q[idx_q] && ram_rdata.pid == req_q.process_id
                       && ram_rdata.page == req_q.page_number;
  assign scan_end    = chk_q && idx_q == last_q;
  assign older       = ram_rdata.stamp < best_q;

  assign ram_re = (state_q == ST_SCAN) && issue_q;

  always_comb begin
    if (req_q.kind == KIND_LOOKUP) begin
      ram_wdata       = ent_q;
      ram_wdata.stamp = counter_inc;
    end else begin
      ram_wdata.pid   = req_q.process_id;
      ram_wdata.page  = req_q.page_number;
      ram_wdata.frame = req_q.frame_number;
      ram_wdata.stamp = counter_q;
    end
  end

  always_comb begin
    state_d     = state_q;
    valid_d     = valid_q;
    counter_d   = counter_q;
    out_valid_d = out_valid_q;
    issue_d     = issue_q;
    chk_d       = chk_q;
    wr_d        = wr_q;
    hit_d       = hit_q;
    req_d       = req_q;
    addr_d      = addr_q;
    idx_d       = idx_q;
    last_d      = last_q;
    vic_d       = vic_q;
    slot_d      = slot_q;
    best_d      = best_q;
    ent_d       = ent_q;
    out_d       = out_q;
    ram_we      = 1'b0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d   = in_word_i;
          addr_d  = '0;
          issue_d = 1'b1;
          chk_d   = 1'b0;
          best_d  = counter_q;
          vic_d   = '0;
          wr_d    = 1'b0;
          hit_d   = 1'b0;
          slot_d  = '0;
          if (in_word_i.kind == KIND_INVAL) begin
            last_d = IDX_W'(ENTRIES - 1);
          end else begin
            last_d = IDX_W'(n_cnt - CNT_W'(1));
          end
          unique case (in_word_i.kind)
            KIND_LOOKUP: begin
              state_d = (n_cnt == '0) ? ST_FINISH : ST_SCAN;
            end
            KIND_FILL: begin
              if (n_cnt == '0) begin
                state_d = ST_FINISH;
              end else if (free_found) begin
                slot_d  = free_idx;
                wr_d    = 1'b1;
                state_d = ST_FINISH;
              end else begin
                state_d = ST_SCAN;
              end
            end
            KIND_INVAL: begin
              state_d = ST_SCAN;
            end
            KIND_FLUSH: begin
              valid_d = '0;
              state_d = ST_FINISH;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // issue one read a cycle, check the entry read the cycle before
        if (issue_q) begin
          chk_d = 1'b1;
          idx_d = addr_q;
          if (addr_q == last_q) begin
            issue_d = 1'b0;
          end else begin
            addr_d = addr_q + IDX_W'(1);
          end
        end else begin
          chk_d = 1'b0;
        end
        if (chk_q) begin
          case (req_q.kind)
            KIND_LOOKUP: begin
              if (scan_hit) begin
                hit_d   = 1'b1;
                wr_d    = 1'b1;
                slot_d  = idx_q;
                ent_d   = ram_rdata;
                issue_d = 1'b0;
                chk_d   = 1'b0;
                state_d = ST_FINISH;
              end else if (scan_end) begin
                chk_d   = 1'b0;
                state_d = ST_FINISH;
              end
            end
            KIND_FILL: begin
              if (older) begin
                best_d = ram_rdata.stamp;
                vic_d  = idx_q;
              end
              if (scan_end) begin
                slot_d  = older ? idx_q : vic_q;
                wr_d    = 1'b1;
                chk_d   = 1'b0;
                state_d = ST_FINISH;
              end
            end
            KIND_INVAL: begin
              if (valid_q[idx_q] && ram_rdata.pid == req_q.process_id) begin
                valid_d[idx_q] = 1'b0;
              end
              if (scan_end) begin
                chk_d   = 1'b0;
                state_d = ST_FINISH;
              end
            end
            default: begin
              issue_d = 1'b0;
              chk_d   = 1'b0;
              state_d = ST_FINISH;
            end
          endcase
        end
      end

      ST_FINISH: begin
        if (out_free) begin
          ram_we          = wr_q;
          out_valid_d     = 1'b1;
          out_d.hit       = hit_q;
          out_d.frame_out = hit_q ? ent_q.frame : '0;
          out_d.slot_used = wr_q ? SLOT_W'(slot_q) : '0;
          if (wr_q) begin
            counter_d = counter_inc;
            if (req_q.kind == KIND_FILL) begin
              valid_d[slot_q] = req_q.process_id != '0;
            end
          end
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      counter_q   <= '0;
      cfg_q       <= CFG_RESET;
      out_valid_q <= 1'b0;
      issue_q     <= 1'b0;
      chk_q       <= 1'b0;
      wr_q        <= 1'b0;
      hit_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      counter_q   <= counter_d;
      out_valid_q <= out_valid_d;
      issue_q     <= issue_d;
      chk_q       <= chk_d;
      wr_q        <= wr_d;
      hit_q       <= hit_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    addr_q <= addr_d;
    idx_q  <= idx_d;
    last_q <= last_d;
    vic_q  <= vic_d;
    slot_q <= slot_d;
    best_q <= best_d;
    ent_q  <= ent_d;
    out_q  <= out_d;
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// File: rtl/core/tlbl_entry_ram.sv
// entry memory: one write port, one read port with registered read data
module tlbl_entry_ram
  import tlbl_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  entry_t                                    wdata_i,
  input  logic                                      re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output entry_t                                    rdata_o
);

  entry_t mem [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
